// ===== src/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types, constants and helpers of the HWC to CHW image normalizer.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int FIELD_W     = 16;
    localparam int PACK_W      = 48;
    localparam int VALUE_W     = 32;
    localparam int DEST_W      = 26;
    localparam int ROW_BASE_W  = 24;
    localparam int COL_ITEM_W  = 16;
    localparam int CH_W        = 2;
    localparam int NC_W        = 3;
    localparam int CFG_WIDTH_W = 13;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_NC_W    = 2;
    localparam int PROD_W      = 34;
    localparam int ROUND_SHIFT = 8;

    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_SEL_LSB = 3;
    localparam int REG_SEL_W   = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_MAX_CHANNELS = 3;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMG_WIDTH     = 13'd224;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMG_HEIGHT    = 13'd224;
    localparam logic [CFG_NC_W-1:0]     RST_CHANNEL_COUNT = 2'd3;
    localparam logic                    RST_NORMALIZE     = 1'b0;
    localparam logic [PACK_W-1:0]       RST_MEANS         = 48'h0;
    localparam logic [PACK_W-1:0]       RST_INV_STD       = 48'h0100_0100_0100;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_IMG_WIDTH,
        REG_IMG_HEIGHT,
        REG_CHANNEL_COUNT,
        REG_NORMALIZE_ENABLE,
        REG_CHANNEL_MEANS,
        REG_CHANNEL_INV_STD
    } reg_index_t;

    typedef struct packed {
        logic              normalize;
        logic [PACK_W-1:0] means;
        logic [PACK_W-1:0] inv_std;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic [CH_W-1:0]       ch;
        logic [COL_ITEM_W-1:0] col;
        logic [ROW_BASE_W-1:0] row_base;
        logic                  frame_end;
    } q_item_t;

    typedef struct packed {
        logic pop;
        logic s1_valid;
    } bk_stat_t;

    function automatic logic [FIELD_W-1:0] select_field(input logic [PACK_W-1:0] word,
                                                        input logic [CH_W-1:0] ch);
        logic [FIELD_W-1:0] f;
        case (ch)
            2'd0:    f = word[FIELD_W-1:0];
            2'd1:    f = word[2*FIELD_W-1:FIELD_W];
            2'd2:    f = word[3*FIELD_W-1:2*FIELD_W];
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== src/ihc_regs.sv =====
// ----------------------------------------------------------------------------
// ihc_regs
// APB register file; presents clamped geometry and normalization settings.
// ----------------------------------------------------------------------------
module ihc_regs #(
    parameter int MAX_WIDTH    = ihc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = ihc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = ihc_pkg::DEF_MAX_CHANNELS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ihc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ihc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ihc_pkg::APB_DATA_W-1:0]   prdata,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   width_val,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]  height_val,
    output logic [ihc_pkg::NC_W-1:0]         nc_val,
    output ihc_pkg::cfg_t                    cfg
);
    import ihc_pkg::*;

    localparam int WV_W = $clog2(MAX_WIDTH + 1);
    localparam int HV_W = $clog2(MAX_HEIGHT + 1);

    logic [CFG_WIDTH_W-1:0]  img_width_reg;
    logic [CFG_HEIGHT_W-1:0] img_height_reg;
    logic [CFG_NC_W-1:0]     channel_count_reg;
    logic                    normalize_enable_reg;
    logic [PACK_W-1:0]       channel_means_reg;
    logic [PACK_W-1:0]       channel_inv_std_reg;
    logic                    wr_en;
    reg_index_t              sel;

    assign wr_en = psel && penable && pwrite;
    assign sel   = reg_index_t'(paddr[REG_SEL_LSB +: REG_SEL_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg        <= RST_IMG_WIDTH;
            img_height_reg       <= RST_IMG_HEIGHT;
            channel_count_reg    <= RST_CHANNEL_COUNT;
            normalize_enable_reg <= RST_NORMALIZE;
            channel_means_reg    <= RST_MEANS;
            channel_inv_std_reg  <= RST_INV_STD;
        end else if (wr_en) begin
            case (sel)
                REG_IMG_WIDTH:        img_width_reg        <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMG_HEIGHT:       img_height_reg       <= pwdata[CFG_HEIGHT_W-1:0];
                REG_CHANNEL_COUNT:    channel_count_reg    <= pwdata[CFG_NC_W-1:0];
                REG_NORMALIZE_ENABLE: normalize_enable_reg <= pwdata[0];
                REG_CHANNEL_MEANS:    channel_means_reg    <= pwdata[PACK_W-1:0];
                REG_CHANNEL_INV_STD:  channel_inv_std_reg  <= pwdata[PACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_IMG_WIDTH:        prdata = APB_DATA_W'(img_width_reg);
            REG_IMG_HEIGHT:       prdata = APB_DATA_W'(img_height_reg);
            REG_CHANNEL_COUNT:    prdata = APB_DATA_W'(channel_count_reg);
            REG_NORMALIZE_ENABLE: prdata = APB_DATA_W'(normalize_enable_reg);
            REG_CHANNEL_MEANS:    prdata = APB_DATA_W'(channel_means_reg);
            REG_CHANNEL_INV_STD:  prdata = APB_DATA_W'(channel_inv_std_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        if (img_width_reg == '0) begin
            width_val = WV_W'(1);
        end else if (32'(img_width_reg) > 32'(MAX_WIDTH)) begin
            width_val = WV_W'(MAX_WIDTH);
        end else begin
            width_val = WV_W'(img_width_reg);
        end
        if (img_height_reg == '0) begin
            height_val = HV_W'(1);
        end else if (32'(img_height_reg) > 32'(MAX_HEIGHT)) begin
            height_val = HV_W'(MAX_HEIGHT);
        end else begin
            height_val = HV_W'(img_height_reg);
        end
        if (channel_count_reg == '0) begin
            nc_val = NC_W'(1);
        end else if (32'(channel_count_reg) > 32'(MAX_CHANNELS)) begin
            nc_val = NC_W'(MAX_CHANNELS);
        end else begin
            nc_val = NC_W'(channel_count_reg);
        end
    end

    assign cfg.normalize = normalize_enable_reg;
    assign cfg.means     = channel_means_reg;
    assign cfg.inv_std   = channel_inv_std_reg;

endmodule

// ===== src/ihc_front.sv =====
// ----------------------------------------------------------------------------
// ihc_front
// Accepts sample requests, tags each with its channel, column, row base and
// frame end, and advances the position counters.
// ----------------------------------------------------------------------------
module ihc_front #(
    parameter int MAX_WIDTH  = ihc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ihc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ihc_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_val,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  height_val,
    input  logic [ihc_pkg::NC_W-1:0]         nc_val,
    input  logic                             q_full,
    output logic                             q_push,
    output ihc_pkg::q_item_t                 q_item
);
    import ihc_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CH_W-1:0]       ch_reg, ch_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ROW_BASE_W-1:0] row_base_reg, row_base_next;
    logic                  last_ch, last_col, last_row;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign last_ch  = (NC_W'(ch_reg) + NC_W'(1)) >= nc_val;
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(width_val);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(height_val);

    always_comb begin
        ch_next       = ch_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (!last_ch) begin
            ch_next = ch_reg + CH_W'(1);
        end else begin
            ch_next = '0;
            if (!last_col) begin
                col_next = col_reg + COL_W'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next      = row_reg + ROW_W'(1);
                    row_base_next = ROW_BASE_W'(32'(row_base_reg) + 32'(width_val));
                end else begin
                    row_next      = '0;
                    row_base_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg       <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end else if (q_push) begin
            ch_reg       <= ch_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

    assign q_item.sample    = s_sample;
    assign q_item.ch        = ch_reg;
    assign q_item.col       = COL_ITEM_W'(col_reg);
    assign q_item.row_base  = row_base_reg;
    assign q_item.frame_end = last_ch && last_col && last_row;

endmodule

// ===== src/ihc_queue.sv =====
// ----------------------------------------------------------------------------
// ihc_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module ihc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ihc_pkg::q_item_t push_item,
    input  logic             pop,
    output logic             q_valid,
    output logic             q_full,
    output ihc_pkg::q_item_t pop_item
);
    import ihc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_valid  = count_reg != '0;
    assign q_full   = count_reg == CNT_W'(QUEUE_DEPTH);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/ihc_back.sv =====
// ----------------------------------------------------------------------------
// ihc_back
// Two-stage datapath: multiply stage, then rounding and planar index stage
// feeding the output register.
// ----------------------------------------------------------------------------
module ihc_back #(
    parameter int MAX_WIDTH  = ihc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ihc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  ihc_pkg::q_item_t                 q_item,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_val,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  height_val,
    input  ihc_pkg::cfg_t                    cfg,
    output ihc_pkg::bk_stat_t                stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [ihc_pkg::VALUE_W-1:0] m_value,
    output logic [ihc_pkg::DEST_W-1:0]       m_dest_index,
    output logic                             m_frame_end
);
    import ihc_pkg::*;

    localparam int WV_W = $clog2(MAX_WIDTH + 1);
    localparam int HV_W = $clog2(MAX_HEIGHT + 1);

    logic                      out_adv, s1_adv, pop;
    logic [FIELD_W-1:0]        mean, inv;
    logic [FIELD_W-1:0]        scaled;
    logic signed [FIELD_W:0]   diff;
    logic signed [PROD_W-1:0]  prod;
    logic [WV_W+HV_W-1:0]      wh_full;

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg;
    logic [FIELD_W-1:0]        s1_scaled_reg;
    logic [DEST_W-1:0]         s1_wh_reg;
    logic [DEST_W-1:0]         s1_base_reg;
    logic [CH_W-1:0]           s1_ch_reg;
    logic                      s1_end_reg;

    logic signed [PROD_W-1:0]  rounded;
    logic [VALUE_W-1:0]        value_next;
    logic [DEST_W-1:0]         plane, dest_next;

    logic                      m_valid_reg;
    logic [VALUE_W-1:0]        m_value_reg;
    logic [DEST_W-1:0]         m_dest_reg;
    logic                      m_end_reg;

    assign out_adv = !m_valid_reg || m_ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = q_valid && s1_adv;

    assign stat.pop      = pop;
    assign stat.s1_valid = s1_valid_reg;

    assign mean    = select_field(cfg.means, q_item.ch);
    assign inv     = select_field(cfg.inv_std, q_item.ch);
    assign scaled  = {q_item.sample, q_item.sample};
    assign diff    = $signed({1'b0, scaled}) - $signed({1'b0, mean});
    assign prod    = diff * $signed({1'b0, inv});
    assign wh_full = width_val * height_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_prod_reg   <= prod;
            s1_scaled_reg <= scaled;
            s1_wh_reg     <= DEST_W'(wh_full);
            s1_base_reg   <= DEST_W'(q_item.row_base) + DEST_W'(q_item.col);
            s1_ch_reg     <= q_item.ch;
            s1_end_reg    <= q_item.frame_end;
        end
    end

    assign rounded = s1_prod_reg + PROD_W'(128);
    assign plane   = (s1_ch_reg[0] ? s1_wh_reg : '0)
                   + (s1_ch_reg[1] ? {s1_wh_reg[DEST_W-2:0], 1'b0} : '0);
    assign dest_next = plane + s1_base_reg;

    always_comb begin
        if (cfg.normalize) begin
            value_next = {{(VALUE_W-PROD_W+ROUND_SHIFT){rounded[PROD_W-1]}},
                          rounded[PROD_W-1:ROUND_SHIFT]};
        end else begin
            value_next = VALUE_W'(s1_scaled_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_value_reg <= value_next;
            m_dest_reg  <= dest_next;
            m_end_reg   <= s1_end_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = $signed(m_value_reg);
    assign m_dest_index = m_dest_reg;
    assign m_frame_end  = m_end_reg;

endmodule

// ===== src/image_normalize_hwc_to_chw.sv =====
// ----------------------------------------------------------------------------
// image_normalize_hwc_to_chw
// Normalizes an interleaved 8-bit image stream to signed Q16.16 and tags each
// result with its planar destination index and an end-of-frame mark.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     s_sample
//  m_        out        m_valid / m_ready     m_value, m_dest_index, m_frame_end
//  apb       in         psel, penable, pready pwrite, paddr, pwdata, prdata
//
//  One request per cycle sustained while m_ready is high; a request passes the
//  queue, multiply stage and rounding/index stage into the output register.
//  Synchronous active-low reset clears counters, queue, stage valids and loads
//  register defaults. A four-request queue absorbs stalls on the m_ side;
//  s_ready drops only while it is full.
// ----------------------------------------------------------------------------
module image_normalize_hwc_to_chw #(
    parameter int MAX_WIDTH    = ihc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = ihc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = ihc_pkg::DEF_MAX_CHANNELS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ihc_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ihc_pkg::VALUE_W-1:0] m_value,
    output logic [ihc_pkg::DEST_W-1:0]         m_dest_index,
    output logic                               m_frame_end,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ihc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ihc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ihc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ihc_pkg::*;

    localparam int WV_W = $clog2(MAX_WIDTH + 1);
    localparam int HV_W = $clog2(MAX_HEIGHT + 1);

    logic [WV_W-1:0] width_val;
    logic [HV_W-1:0] height_val;
    logic [NC_W-1:0] nc_val;
    cfg_t            cfg;
    logic            q_push, q_valid, q_full;
    q_item_t         push_item, pop_item;
    bk_stat_t        stat;

    assign pready = 1'b1;

    ihc_regs #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .width_val (width_val),
        .height_val(height_val),
        .nc_val    (nc_val),
        .cfg       (cfg)
    );

    ihc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .width_val (width_val),
        .height_val(height_val),
        .nc_val    (nc_val),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ihc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_item(push_item),
        .pop      (stat.pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .pop_item (pop_item)
    );

    ihc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .width_val   (width_val),
        .height_val  (height_val),
        .cfg         (cfg),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_dest_index(m_dest_index),
        .m_frame_end (m_frame_end)
    );

    a_idle_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !q_valid && !stat.s1_valid && !m_valid) |-> ##3 m_valid)
        else $error("request through an idle pipeline did not reach the output");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && stat.s1_valid) |-> !stat.pop)
        else $error("queue popped while the first stage was blocked");

    a_pop_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pop |=> stat.s1_valid)
        else $error("popped request lost before the first stage");

endmodule

// ===== sim/chw_result_checker.sv =====
// ----------------------------------------------------------------------------
// chw_result_checker
// Watches the sample, result and register channels of the HWC to CHW
// normalizer. Register writes are tracked to keep a private copy of the
// setup. Each accepted sample is normalized and placed at its planar position
// to give the expected result. Every result taken by the sink is compared
// field by field with the oldest expected one. Mismatches and the number of
// results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module chw_result_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [ihc_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [ihc_pkg::VALUE_W-1:0] m_value,
    input  logic [ihc_pkg::DEST_W-1:0]         m_dest_index,
    input  logic                               m_frame_end,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [ihc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ihc_pkg::APB_DATA_W-1:0]     pwdata,
    output int                                 mismatches,
    output int                                 pending
);
    import ihc_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [DEST_W-1:0]         dest;
        logic                      frame_end;
    } chw_result_t;

    chw_result_t expected_results[$];

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_NC_W-1:0]     channels_reg;
    logic                    normalize_reg;
    logic [PACK_W-1:0]       means_reg;
    logic [PACK_W-1:0]       inv_std_reg;

    logic [11:0]             col_pos;
    logic [11:0]             row_pos;
    logic [CH_W-1:0]         chan_pos;
    logic [ROW_BASE_W-1:0]   row_start;

    initial begin
        mismatches = 0;
        pending = 0;
    end

    function automatic longint unsigned clamp_dim(input longint unsigned v,
                                                  input longint unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned lane(input logic [PACK_W-1:0] word,
                                             input logic [CH_W-1:0] ch);
        if (ch > 2) return 0;
        return (word >> (FIELD_W * ch)) & 48'hFFFF;
    endfunction

    task automatic report_mismatch(input string line);
        $display("ERROR %0t: %s", $time, line);
        mismatches++;
    endtask

    task automatic normalize_sample(input logic [SAMPLE_W-1:0] x, output chw_result_t r);
        longint unsigned w, h, nc, dest;
        longint scaled, t;
        logic last_ch, last_col, last_row;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        nc = clamp_dim(channels_reg, DEF_MAX_CHANNELS);
        scaled = longint'(x) * 257;
        if (normalize_reg) begin
            t = (scaled - longint'(lane(means_reg, chan_pos)))
                * longint'(lane(inv_std_reg, chan_pos)) + 128;
            r.value = VALUE_W'(t >>> 8);
        end else begin
            r.value = VALUE_W'(scaled);
        end
        dest = longint'(chan_pos) * (w * h) + longint'(row_start) + longint'(col_pos);
        r.dest = DEST_W'(dest);
        last_ch = (longint'(chan_pos) + 1) >= nc;
        last_col = (longint'(col_pos) + 1) >= w;
        last_row = (longint'(row_pos) + 1) >= h;
        r.frame_end = last_ch && last_col && last_row;
        // advance channel, then column, then row
        if (!last_ch) begin
            chan_pos = chan_pos + 1'b1;
        end else begin
            chan_pos = '0;
            if (!last_col) begin
                col_pos = col_pos + 1'b1;
            end else begin
                col_pos = '0;
                if (!last_row) begin
                    row_pos = row_pos + 1'b1;
                    row_start = row_start + ROW_BASE_W'(w);
                end else begin
                    row_pos = '0;
                    row_start = '0;
                end
            end
        end
    endtask

    always @(posedge aclk) begin : observe
        chw_result_t want;
        if (!aresetn) begin
            width_reg = RST_IMG_WIDTH;
            height_reg = RST_IMG_HEIGHT;
            channels_reg = RST_CHANNEL_COUNT;
            normalize_reg = RST_NORMALIZE;
            means_reg = RST_MEANS;
            inv_std_reg = RST_INV_STD;
            col_pos = '0;
            row_pos = '0;
            chan_pos = '0;
            row_start = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no pending request, dest %0d",
                                              m_dest_index));
                end else begin
                    want = expected_results.pop_front();
                    if (m_value !== want.value)
                        report_mismatch($sformatf("value got %0d want %0d (dest %0d)",
                                                  m_value, want.value, want.dest));
                    if (m_dest_index !== want.dest)
                        report_mismatch($sformatf("dest_index got %0d want %0d",
                                                  m_dest_index, want.dest));
                    if (m_frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %0b want %0b (dest %0d)",
                                                  m_frame_end, want.frame_end, want.dest));
                end
            end
            if (s_valid && s_ready) begin
                normalize_sample(s_sample, want);
                expected_results.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[REG_SEL_LSB +: REG_SEL_W]))
                    REG_IMG_WIDTH:        width_reg = pwdata[CFG_WIDTH_W-1:0];
                    REG_IMG_HEIGHT:       height_reg = pwdata[CFG_HEIGHT_W-1:0];
                    REG_CHANNEL_COUNT:    channels_reg = pwdata[CFG_NC_W-1:0];
                    REG_NORMALIZE_ENABLE: normalize_reg = pwdata[0];
                    REG_CHANNEL_MEANS:    means_reg = pwdata[PACK_W-1:0];
                    REG_CHANNEL_INV_STD:  inv_std_reg = pwdata[PACK_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= expected_results.size();
    end

endmodule

// ===== sim/image_normalize_hwc_to_chw_tb.sv =====
// ----------------------------------------------------------------------------
// image_normalize_hwc_to_chw_tb
// Drives sample streams and register setups into the HWC to CHW normalizer.
// A directed opening covers the sample extremes, the normalization extremes,
// zero and oversized geometry and geometry changed inside a frame. Random
// phases follow, each with a fresh setup written while the block is drained,
// and random gaps and stalls on both channels. The checker instance does all
// prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module image_normalize_hwc_to_chw_tb;
    import ihc_pkg::*;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [SAMPLE_W-1:0]         s_sample = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [VALUE_W-1:0]   m_value;
    logic [DEST_W-1:0]           m_dest_index;
    logic                        m_frame_end;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr = '0;
    logic [APB_DATA_W-1:0]       pwdata = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    int                          mismatches;
    int                          pending;
    logic                        tx_calm = 1'b0;
    logic                        rx_calm = 1'b0;
    int                          rx_hold = 0;

    image_normalize_hwc_to_chw u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_dest_index(m_dest_index), .m_frame_end(m_frame_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    chw_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_dest_index(m_dest_index), .m_frame_end(m_frame_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .pending(pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_W-1:0] any_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_WIDTH_W-1:0] any_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return CFG_WIDTH_W'($urandom_range(1, 6));
        if (r < 84) return '0;
        if (r < 88) return CFG_WIDTH_W'(4096);
        if (r < 91) return CFG_WIDTH_W'(4095);
        if (r < 94) return 13'h1FFF;
        return CFG_WIDTH_W'($urandom);
    endfunction

    function automatic logic [PACK_W-1:0] any_pack();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 24) return '1;
        return PACK_W'({$urandom, $urandom});
    endfunction

    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            rx_hold <= pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // bits above the register width carry noise
    task automatic write_reg(input reg_index_t idx, input logic [63:0] value, input int nbits);
        logic [63:0] mask;
        mask = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, {REG_SEL_LSB{1'b0}}});
        pwdata <= ({$urandom, $urandom} & ~mask) | (value & mask);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] x, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic quiesce();
        wait_drained();
        repeat (4) @(posedge aclk);
    endtask

    task automatic pick_setup();
        if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_IMG_WIDTH, any_dim(), CFG_WIDTH_W);
            write_reg(REG_IMG_HEIGHT, any_dim(), CFG_HEIGHT_W);
            write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 3), CFG_NC_W);
        end
        write_reg(REG_NORMALIZE_ENABLE, $urandom_range(0, 1), 1);
        write_reg(REG_CHANNEL_MEANS, any_pack(), PACK_W);
        write_reg(REG_CHANNEL_INV_STD, any_pack(), PACK_W);
    endtask

    initial begin
        int sent;
        int burst;
        int waited;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setup: scale only, 224x224x3
        send_sample(8'h00, 0);
        send_sample(8'hFF, 0);
        send_sample(8'h55, 0);
        send_sample(8'hAA, 0);

        // zero geometry clamps to one pixel; per-channel normalization extremes
        quiesce();
        write_reg(REG_IMG_WIDTH, 0, CFG_WIDTH_W);
        write_reg(REG_IMG_HEIGHT, 0, CFG_HEIGHT_W);
        write_reg(REG_CHANNEL_COUNT, 3, CFG_NC_W);
        write_reg(REG_NORMALIZE_ENABLE, 1, 1);
        write_reg(REG_CHANNEL_MEANS, 48'h8000_FFFF_0000, PACK_W);
        write_reg(REG_CHANNEL_INV_STD, 48'h0000_FFFF_FFFF, PACK_W);
        send_sample(8'hFF, 0);
        send_sample(8'h00, 0);
        send_sample(8'h80, 0);
        send_sample(8'h00, 0);
        send_sample(8'hFF, 0);
        send_sample(8'hC8, 0);

        // oversized geometry, zero channel count, then channels raised mid-frame
        quiesce();
        write_reg(REG_IMG_WIDTH, 13'h1FFF, CFG_WIDTH_W);
        write_reg(REG_IMG_HEIGHT, 13'h1FFF, CFG_HEIGHT_W);
        write_reg(REG_CHANNEL_COUNT, 0, CFG_NC_W);
        write_reg(REG_NORMALIZE_ENABLE, 0, 1);
        repeat (3) send_sample(any_sample(), 0);
        quiesce();
        write_reg(REG_CHANNEL_COUNT, 3, CFG_NC_W);
        repeat (3) send_sample(any_sample(), 0);

        // shrink geometry below the running column position
        quiesce();
        write_reg(REG_IMG_WIDTH, 2, CFG_WIDTH_W);
        write_reg(REG_IMG_HEIGHT, 2, CFG_HEIGHT_W);
        write_reg(REG_CHANNEL_COUNT, 2, CFG_NC_W);
        write_reg(REG_NORMALIZE_ENABLE, 1, 1);
        repeat (8) send_sample(any_sample(), 0);

        sent = 0;
        while (sent < 1600) begin
            quiesce();
            pick_setup();
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            burst = $urandom_range(10, 150);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 3)
                    wait_drained();
                if (!tx_calm && $urandom_range(0, 99) < 35)
                    send_sample(any_sample(), pick_gap());
                else
                    send_sample(any_sample(), 0);
                sent++;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending != 0)
            $display("ERROR: %0d requests never produced a result", pending);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== image_normalize_hwc_to_chw.f =====
src/ihc_pkg.sv
src/ihc_regs.sv
src/ihc_front.sv
src/ihc_queue.sv
src/ihc_back.sv
src/image_normalize_hwc_to_chw.sv
sim/chw_result_checker.sv
sim/image_normalize_hwc_to_chw_tb.sv
